FILE: hdl/wmcc_pkg.sv
// Shared widths, codes and helpers for the warp memory coalescing counter.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none
package wmcc_pkg;

  // Field widths
  localparam int ADDR_W     = 64;
  localparam int CW         = 48;
  localparam int ABYTES_W   = 16;
  localparam int SPACE_W    = 3;
  localparam int SEGL_W     = 4;
  localparam int LPW_W      = 6;
  localparam int SEG_LOW_W  = 12;

  // Port widths
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 7 * CW;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  // Parameter defaults
  localparam int MAX_WARP_DEFAULT = 32;
  localparam int SPACES_DEFAULT   = 7;

  // Operation and address space codes
  localparam logic OP_MEMORY = 1'b1;
  localparam logic [SPACE_W-1:0] SPACE_GLOBAL  = 3'd1;
  localparam logic [SPACE_W-1:0] SPACE_TEXTURE = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANES_PER_WARP    = 1'd1;
  localparam logic [SEGL_W-1:0]    SEG_LOG2_RESET        = 4'd6;
  localparam logic [SEGL_W-1:0]    SEG_LOG2_MAX          = 4'd12;
  localparam logic [LPW_W-1:0]     LPW_RESET             = 6'd32;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // Saturating add of two counter-wide values.
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CW] ? CNT_MAX : sum[CW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/warp_memory_coalescing_counter_top.sv
// Warp memory coalescing counter: segment set, per-space counters and output stream.
// Depends on wmcc_pkg.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  one trace item (lane or instruction event)
//  m_*       out        m_tvalid/m_tready  counter snapshot after that item
//  cfg_*     in         cfg_we             segment size and warp size registers
//
// One item is accepted per clock when the output side keeps up. Each result passes
// through the input register, loaded by the edge that accepts its request, then the
// update register and then the output register.
// The update register stage compares the lane's segment against every set entry at
// once, so the item rate is set by that stage alone, one per cycle while the output keeps up.
// Reset is synchronous and clears all counters and the set fill count.
// A stall on m_tready backs up through the three stages to s_tready.
`default_nettype none
module warp_memory_coalescing_counter_top
  import wmcc_pkg::*;
#(
  parameter int MAX_WARP = MAX_WARP_DEFAULT,
  parameter int SPACES   = SPACES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // lane_active[0], address[64:1], access_bytes[80:65], zero[87:81]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // op[0], first_lane[1], space[4:2]
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   s_tlast,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // instruction_count[47:0], space_accesses[95:48], space_transactions[143:96],
  // space_bytes[191:144], offchip_accesses[239:192], offchip_transactions[287:240],
  // offchip_bytes[335:288]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_WARP > 1) ? $clog2(MAX_WARP) : 1;
  localparam int CNT_W = $clog2(MAX_WARP + 1);
  localparam int SP_W  = (SPACES > 1) ? $clog2(SPACES) : 1;
  localparam int CMP_W = ((CNT_W > LPW_W) ? CNT_W : LPW_W) + 1;

  // Configuration registers
  logic [SEGL_W-1:0] segment_size_log2;
  logic [LPW_W-1:0]  lanes_per_warp;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size_log2 <= SEG_LOG2_RESET;
      lanes_per_warp    <= LPW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENT_SIZE_LOG2: segment_size_log2 <= cfg_wdata[SEGL_W-1:0];
        CFG_LANES_PER_WARP:    lanes_per_warp    <= cfg_wdata[LPW_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: input register, update register, output register.
  logic a_valid, b_valid;
  logic b_ready, c_ready, a_fire;

  assign c_ready  = !m_tvalid || m_tready;
  assign b_ready  = !b_valid || c_ready;
  assign s_tready = !a_valid || b_ready;
  assign a_fire   = a_valid && b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) a_valid  <= s_tvalid;
      if (b_ready)  b_valid  <= a_valid;
      if (c_ready)  m_tvalid <= b_valid;
    end
  end

  // Input register
  logic               a_op, a_first, a_active, a_bend;
  logic [SPACE_W-1:0] a_space;
  logic [ADDR_W-1:0]  a_address;
  logic [ABYTES_W-1:0] a_abytes;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_op      <= s_tuser[0];
      a_first   <= s_tuser[1];
      a_space   <= s_tuser[4:2];
      a_active  <= s_tdata[0];
      a_address <= s_tdata[ADDR_W:1];
      a_abytes  <= s_tdata[ADDR_W+ABYTES_W:ADDR_W+1];
      a_bend    <= s_tlast;
    end
  end

  // Per-warp state and counters
  logic [ADDR_W-1:0] seg_set [MAX_WARP];
  logic [CNT_W-1:0]  set_count;
  logic [IDX_W-1:0]  lane_index;
  logic [CW-1:0]     instr_total;
  logic [CW-1:0]     acc_ctr [SPACES];
  logic [CW-1:0]     tr_ctr  [SPACES];
  logic [CW-1:0]     by_ctr  [SPACES];

  // Clamped configuration values
  logic [SEGL_W-1:0] seg_log2;
  logic [CNT_W-1:0]  warp_lanes;

  always_comb begin
    seg_log2 = (segment_size_log2 > SEG_LOG2_MAX) ? SEG_LOG2_MAX : segment_size_log2;
    if (lanes_per_warp == '0) begin
      warp_lanes = CNT_W'(1);
    end else if (CMP_W'(lanes_per_warp) > CMP_W'(MAX_WARP)) begin
      warp_lanes = CNT_W'(MAX_WARP);
    end else begin
      warp_lanes = CNT_W'(lanes_per_warp);
    end
  end

  // Item decode
  logic valid_space, is_tex, tex_upd, set_op, instr_inc;
  logic [SP_W-1:0] sp_idx;

  assign valid_space = {1'b0, a_space} < 4'(SPACES);
  assign is_tex      = a_space == SPACE_TEXTURE;
  assign tex_upd     = (a_op == OP_MEMORY) && valid_space && is_tex && a_first;
  assign set_op      = (a_op == OP_MEMORY) && valid_space && !is_tex;
  assign instr_inc   = (a_op != OP_MEMORY) || a_first;
  assign sp_idx      = a_space[SP_W-1:0];

  // Segment of this lane and its lookup in the set
  logic [SEG_LOW_W:0] low_mask;
  logic [ADDR_W-1:0]  seg;
  logic [CNT_W-1:0]   cnt_eff, new_cnt, lane_plus;
  logic [IDX_W-1:0]   lane_eff;
  logic               hit, ins, close, cnt_upd;

  always_comb begin
    low_mask  = ~(((SEG_LOW_W+1)'(1) << seg_log2) - (SEG_LOW_W+1)'(1));
    seg       = {a_address[ADDR_W-1:SEG_LOW_W], a_address[SEG_LOW_W-1:0] & low_mask[SEG_LOW_W-1:0]};
    cnt_eff   = a_first ? '0 : set_count;
    lane_eff  = a_first ? '0 : lane_index;
    hit       = 1'b0;
    for (int i = 0; i < MAX_WARP; i++) begin
      if ((CNT_W'(i) < cnt_eff) && (seg_set[i] == seg)) hit = 1'b1;
    end
    ins       = a_active && !hit && (cnt_eff < CNT_W'(MAX_WARP));
    new_cnt   = cnt_eff + CNT_W'(ins);
    lane_plus = CNT_W'(lane_eff) + CNT_W'(1);
    close     = set_op && ((lane_plus >= warp_lanes) || a_bend);
    cnt_upd   = tex_upd || close;
  end

  // Counter arithmetic for the item's space
  logic [CW-1:0] cur_acc, cur_tr, cur_by;
  logic [CW-1:0] tr_inc, by_inc;
  logic [CW-1:0] sum_acc, sum_tr, sum_by, sum_instr;

  always_comb begin
    cur_acc   = acc_ctr[sp_idx];
    cur_tr    = tr_ctr[sp_idx];
    cur_by    = by_ctr[sp_idx];
    tr_inc    = is_tex ? CW'(1) : CW'(new_cnt);
    by_inc    = is_tex ? CW'(a_abytes) : (CW'(new_cnt) << seg_log2);
    sum_acc   = sat_add(cur_acc, CW'(1));
    sum_tr    = sat_add(cur_tr, tr_inc);
    sum_by    = sat_add(cur_by, by_inc);
    sum_instr = sat_add(instr_total, CW'(1));
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      set_count   <= '0;
      lane_index  <= '0;
      instr_total <= '0;
      for (int i = 0; i < SPACES; i++) begin
        acc_ctr[i] <= '0;
        tr_ctr[i]  <= '0;
        by_ctr[i]  <= '0;
      end
    end else if (a_fire) begin
      if (instr_inc) instr_total <= sum_instr;
      if (set_op) begin
        if (close) begin
          set_count  <= '0;
          lane_index <= '0;
        end else begin
          set_count  <= new_cnt;
          lane_index <= lane_plus[IDX_W-1:0];
        end
      end
      if (cnt_upd) begin
        acc_ctr[sp_idx] <= sum_acc;
        tr_ctr[sp_idx]  <= sum_tr;
        by_ctr[sp_idx]  <= sum_by;
      end
    end
  end

  // Segment set entries hold no reset; only the first set_count are compared.
  always_ff @(posedge clk) begin
    if (a_fire && set_op && ins) seg_set[cnt_eff[IDX_W-1:0]] <= seg;
  end

  // Current global and texture counters, where those spaces exist
  logic [CW-1:0] glb_acc, glb_tr, glb_by, tex_acc, tex_tr, tex_by;
  logic          upd_glb, upd_tex;

  assign upd_glb = cnt_upd && (a_space == SPACE_GLOBAL);
  assign upd_tex = cnt_upd && (a_space == SPACE_TEXTURE);

  if (int'(SPACE_GLOBAL) < SPACES) begin : g_glb
    assign glb_acc = upd_glb ? sum_acc : acc_ctr[SP_W'(SPACE_GLOBAL)];
    assign glb_tr  = upd_glb ? sum_tr  : tr_ctr[SP_W'(SPACE_GLOBAL)];
    assign glb_by  = upd_glb ? sum_by  : by_ctr[SP_W'(SPACE_GLOBAL)];
  end else begin : g_no_glb
    assign glb_acc = '0;
    assign glb_tr  = '0;
    assign glb_by  = '0;
  end

  if (int'(SPACE_TEXTURE) < SPACES) begin : g_tex
    assign tex_acc = upd_tex ? sum_acc : acc_ctr[SP_W'(SPACE_TEXTURE)];
    assign tex_tr  = upd_tex ? sum_tr  : tr_ctr[SP_W'(SPACE_TEXTURE)];
    assign tex_by  = upd_tex ? sum_by  : by_ctr[SP_W'(SPACE_TEXTURE)];
  end else begin : g_no_tex
    assign tex_acc = '0;
    assign tex_tr  = '0;
    assign tex_by  = '0;
  end

  // Update register: snapshot of the counters after this item
  logic [CW-1:0] b_instr, b_sacc, b_str, b_sby;
  logic [CW-1:0] b_gacc, b_gtr, b_gby, b_tacc, b_ttr, b_tby;

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_instr <= instr_inc ? sum_instr : instr_total;
      b_sacc  <= !valid_space ? '0 : (cnt_upd ? sum_acc : cur_acc);
      b_str   <= !valid_space ? '0 : (cnt_upd ? sum_tr  : cur_tr);
      b_sby   <= !valid_space ? '0 : (cnt_upd ? sum_by  : cur_by);
      b_gacc  <= glb_acc;
      b_gtr   <= glb_tr;
      b_gby   <= glb_by;
      b_tacc  <= tex_acc;
      b_ttr   <= tex_tr;
      b_tby   <= tex_by;
    end
  end

  // Output register with the off-chip sums
  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      m_tdata <= {sat_add(b_gby, b_tby), sat_add(b_gtr, b_ttr), sat_add(b_gacc, b_tacc),
                  b_sby, b_str, b_sacc, b_instr};
    end
  end

endmodule
`default_nettype wire

FILE: hdl/wmcc_checker.sv
// Port-level checker for the warp memory coalescing counter, bound to the top level.
// Depends on wmcc_pkg and warp_memory_coalescing_counter_top.
`default_nettype none
module wmcc_checker
  import wmcc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready
);

  logic          in_fire, out_fire;
  logic [2:0]    inflight;
  logic          have_last;
  logic [CW-1:0] last_instr, last_offacc;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // Requests accepted but not yet delivered, and the last delivered counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight  <= '0;
      have_last <= 1'b0;
    end else begin
      inflight <= inflight + 3'(in_fire) - 3'(out_fire);
      if (out_fire) begin
        have_last   <= 1'b1;
        last_instr  <= m_tdata[CW-1:0];
        last_offacc <= m_tdata[5*CW-1:4*CW];
      end
    end
  end

  // No result without an outstanding request, and at most three in flight.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid |-> inflight != 3'd0) and (inflight <= 3'd3))
    else $error("result shown with no matching request or too many in flight");

  // The instruction total never falls between delivered results.
  a_instr_mono: assert property (@(posedge clk) disable iff (rst)
    out_fire && have_last |-> m_tdata[CW-1:0] >= last_instr)
    else $error("instruction count decreased");

  // Off-chip accesses never fall between delivered results.
  a_offacc_mono: assert property (@(posedge clk) disable iff (rst)
    out_fire && have_last |-> m_tdata[5*CW-1:4*CW] >= last_offacc)
    else $error("off-chip access count decreased");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind warp_memory_coalescing_counter_top wmcc_checker u_wmcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire
